>>> hdl/ccl_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the console command-line lexer.
// No dependencies; imported by ccl_lex, ccl_emit and the top level.
package ccl_pkg;

  localparam int MAX_RES = 6;
  localparam int RES_IW  = $clog2(MAX_RES);
  localparam int RES_CW  = $clog2(MAX_RES + 1);

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum logic [1:0] {
    EV_CHAR = 2'd0,
    EV_END  = 2'd1,
    EV_LINE = 2'd2
  } ccl_ev_t;

  typedef enum logic [1:0] {
    MODE_GAP    = 2'd0,
    MODE_BARE   = 2'd1,
    MODE_QUOTED = 2'd2,
    MODE_DONE   = 2'd3
  } ccl_mode_t;

  typedef struct packed {
    ccl_ev_t     ev;
    logic [7:0]  chr;
    logic [5:0]  idx;
    logic [9:0]  len;
    logic [6:0]  cnt;
  } ccl_event_t;

  typedef struct packed {
    ccl_event_t [MAX_RES-1:0] ev;
    logic [RES_CW-1:0]        n;
  } ccl_batch_t;

endpackage

>>> hdl/ccl_lex.sv
`timescale 1ns / 1ps
// Line splitter and tokenizer: line/quote/comment state plus one-byte lookahead.
// Produces the batch of events for one byte. Depends on ccl_pkg.
module ccl_lex #(
  parameter int MAX_TOKENS  = 64,
  parameter int TOKEN_CHARS = 1024,
  parameter int LINE_CHARS  = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic [7:0]         byte_value,
  input  logic               end_of_buffer,
  output ccl_pkg::ccl_batch_t batch
);
  import ccl_pkg::*;

  localparam int TCW = $clog2(TOKEN_CHARS);
  localparam int TTW = $clog2(MAX_TOKENS + 1);
  localparam int KW  = $clog2(LINE_CHARS);
  localparam logic [TCW-1:0] TOK_LIM  = TCW'(TOKEN_CHARS - 1);
  localparam logic [TTW-1:0] TOK_MAX  = TTW'(MAX_TOKENS);
  localparam logic [KW-1:0]  KEEP_LIM = KW'(LINE_CHARS - 1);

  typedef struct packed {
    ccl_mode_t        mode;
    logic             lit;
    logic [TCW-1:0]   ccnt;
    logic [TTW-1:0]   total;
  } lst_t;

  typedef struct packed {
    lst_t        st;
    logic [1:0]  n;
    ccl_event_t  e0;
    ccl_event_t  e1;
  } lres_t;

  function automatic lres_t mk(lst_t s);
    lres_t r;
    r.st = s;
    r.n  = 2'd0;
    r.e0 = '0;
    r.e1 = '0;
    return r;
  endfunction

  function automatic lres_t add(lres_t r, ccl_event_t e);
    lres_t o;
    o = r;
    if (r.n == 2'd0) begin
      o.e0 = e;
    end else begin
      o.e1 = e;
    end
    o.n = r.n + 2'd1;
    return o;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic lres_t put_char(lres_t r, logic [7:0] c);
    ccl_event_t e;
    lres_t o;
    e     = '0;
    e.ev  = EV_CHAR;
    e.chr = c;
    e.idx = 6'(r.st.total);
    o = add(r, e);
    o.st.ccnt = r.st.ccnt + TCW'(1);
    return o;
  endfunction

  function automatic lres_t finish(lres_t r);
    ccl_event_t e;
    lres_t o;
    e     = '0;
    e.ev  = EV_END;
    e.idx = 6'(r.st.total);
    e.len = 10'(r.st.ccnt);
    o = add(r, e);
    o.st.total = r.st.total + TTW'(1);
    o.st.ccnt  = '0;
    o.st.lit   = 1'b0;
    o.st.mode  = (o.st.total == TOK_MAX) ? MODE_DONE : MODE_GAP;
    return o;
  endfunction

  function automatic lres_t do_gap(lres_t r, logic [7:0] c, logic [7:0] nx);
    lres_t o;
    o = r;
    if (r.st.mode == MODE_GAP) begin
      if (c == CH_NUL || (c == CH_SLASH && nx == CH_SLASH)) begin
        o.st.mode = MODE_DONE;
      end else if (!is_blank(c)) begin
        o.st.ccnt = '0;
        if (c == CH_QUOTE) begin
          o.st.mode = MODE_QUOTED;
        end else begin
          o.st.mode = MODE_BARE;
          o = put_char(o, c);
        end
      end
    end
    return o;
  endfunction

  function automatic lres_t lex_step(lst_t s, logic [7:0] c, logic [7:0] nx);
    lres_t r;
    r = mk(s);
    case (s.mode)
      MODE_GAP: begin
        r = do_gap(r, c, nx);
      end
      MODE_BARE: begin
        if (c == CH_NUL || is_blank(c) || (c == CH_SLASH && nx == CH_SLASH) ||
            s.ccnt >= TOK_LIM) begin
          r = do_gap(finish(r), c, nx);
        end else begin
          r = put_char(r, c);
        end
      end
      MODE_QUOTED: begin
        if (s.lit) begin
          r.st.lit = 1'b0;
          r = put_char(r, c);
        end else if (c == CH_NUL) begin
          r = do_gap(finish(r), c, nx);
        end else if (c == CH_QUOTE) begin
          r = finish(r);
        end else if (s.ccnt >= TOK_LIM) begin
          r = do_gap(finish(r), c, nx);
        end else if (c == CH_BSLASH && (nx == CH_QUOTE || nx == CH_BSLASH)) begin
          r.st.lit = 1'b1;
        end else begin
          r = put_char(r, c);
        end
      end
      default: begin
        r = mk(s);
      end
    endcase
    return r;
  endfunction

  logic [7:0]      held_r, held_nxt;
  logic            hv_r, hv_nxt;
  logic            ic_r, ic_nxt;
  logic            par_r, par_nxt;
  logic            ps_r, ps_nxt;
  logic [KW-1:0]   kept_r, kept_nxt;
  ccl_mode_t       mode_r, mode_nxt;
  logic            lit_r, lit_nxt;
  logic [TCW-1:0]  ccnt_r, ccnt_nxt;
  logic [TTW-1:0]  total_r, total_nxt;

  always_comb begin
    lst_t                    s0;
    lres_t                   r1, r2, r3;
    logic                    term;
    logic                    keep;
    ccl_event_t              eol;
    ccl_event_t [MAX_RES-1:0] cand;
    logic [MAX_RES-1:0]      cv;
    logic [RES_CW-1:0]       k;

    s0.mode  = mode_r;
    s0.lit   = lit_r;
    s0.ccnt  = ccnt_r;
    s0.total = total_r;

    ic_nxt  = ic_r;
    par_nxt = par_r;
    ps_nxt  = ps_r;
    term    = 1'b0;
    if (byte_value == CH_NL) begin
      term = 1'b1;
    end else begin
      ic_nxt  = ic_r | (ps_r & (byte_value == CH_SLASH));
      par_nxt = par_r ^ (!ic_nxt && byte_value == CH_QUOTE);
      term    = !ic_nxt && !par_nxt && (byte_value == CH_SEMI);
      ps_nxt  = (byte_value == CH_SLASH);
    end

    keep     = !term && (kept_r < KEEP_LIM);
    r1       = mk(s0);
    held_nxt = held_r;
    hv_nxt   = hv_r;
    kept_nxt = kept_r;
    if (keep) begin
      kept_nxt = kept_r + KW'(1);
      if (hv_r) begin
        r1 = lex_step(s0, held_r, byte_value);
      end
      held_nxt = byte_value;
      hv_nxt   = 1'b1;
    end

    r2  = mk(r1.st);
    r3  = mk(r1.st);
    eol = '0;
    cv[5] = 1'b0;
    if (term || end_of_buffer) begin
      if (hv_nxt) begin
        r2 = lex_step(r1.st, held_nxt, CH_NUL);
      end
      r3 = mk(r2.st);
      if (r2.st.mode == MODE_BARE || r2.st.mode == MODE_QUOTED) begin
        r3 = finish(r3);
      end
      eol.ev  = EV_LINE;
      eol.cnt = 7'(r3.st.total);
      cv[5]   = 1'b1;
    end

    mode_nxt  = r3.st.mode;
    lit_nxt   = r3.st.lit;
    ccnt_nxt  = r3.st.ccnt;
    total_nxt = r3.st.total;
    if (term || end_of_buffer) begin
      held_nxt  = '0;
      hv_nxt    = 1'b0;
      ic_nxt    = 1'b0;
      par_nxt   = 1'b0;
      ps_nxt    = 1'b0;
      kept_nxt  = '0;
      mode_nxt  = MODE_GAP;
      lit_nxt   = 1'b0;
      ccnt_nxt  = '0;
      total_nxt = '0;
    end

    cand[0] = r1.e0;  cv[0] = (r1.n != 2'd0);
    cand[1] = r1.e1;  cv[1] = (r1.n == 2'd2);
    cand[2] = r2.e0;  cv[2] = (r2.n != 2'd0);
    cand[3] = r2.e1;  cv[3] = (r2.n == 2'd2);
    cand[4] = r3.e0;  cv[4] = (r3.n != 2'd0);
    cand[5] = eol;

    batch.ev = '0;
    k = '0;
    for (int i = 0; i < MAX_RES; i++) begin
      if (cv[i]) begin
        batch.ev[k[RES_IW-1:0]] = cand[i];
        k = k + RES_CW'(1);
      end
    end
    batch.n = k;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= '0;
      hv_r    <= 1'b0;
      ic_r    <= 1'b0;
      par_r   <= 1'b0;
      ps_r    <= 1'b0;
      kept_r  <= '0;
      mode_r  <= MODE_GAP;
      lit_r   <= 1'b0;
      ccnt_r  <= '0;
      total_r <= '0;
    end else if (step) begin
      held_r  <= held_nxt;
      hv_r    <= hv_nxt;
      ic_r    <= ic_nxt;
      par_r   <= par_nxt;
      ps_r    <= ps_nxt;
      kept_r  <= kept_nxt;
      mode_r  <= mode_nxt;
      lit_r   <= lit_nxt;
      ccnt_r  <= ccnt_nxt;
      total_r <= total_nxt;
    end
  end

endmodule

>>> hdl/ccl_emit.sv
`timescale 1ns / 1ps
// Result buffer: holds the event batch of one item and hands events out one per cycle while out_ready is high.
// Depends on ccl_pkg.
module ccl_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  ccl_pkg::ccl_batch_t batch,
  output logic                load_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output ccl_pkg::ccl_event_t out_ev,
  output logic                out_last
);
  import ccl_pkg::*;

  ccl_event_t [MAX_RES-1:0] q_r;
  logic [RES_CW-1:0]        n_r;
  logic [RES_IW-1:0]        p_r;
  logic                     pop;

  assign out_valid  = (n_r != '0);
  assign out_last   = ((RES_CW'(p_r) + RES_CW'(1)) == n_r);
  assign out_ev     = q_r[p_r];
  assign pop        = out_valid && out_ready;
  assign load_ready = !out_valid || (pop && out_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= '0;
      p_r <= '0;
    end else if (load) begin
      n_r <= batch.n;
      p_r <= '0;
    end else if (pop) begin
      if (out_last) begin
        n_r <= '0;
        p_r <= '0;
      end else begin
        p_r <= p_r + RES_IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q_r <= batch.ev;
    end
  end

endmodule

>>> hdl/console_command_line_lexer.sv
`timescale 1ns / 1ps
// Console command-line lexer top level: input register, lexer and result buffer.
// Depends on ccl_pkg, ccl_lex and ccl_emit.
//
// Usage:
//   Input channel in_valid/in_ready carries one command-buffer byte per item,
//   with in_end_of_buffer marking the final byte now in the buffer.
//   Result channel out_valid/out_ready carries one event per item: token
//   character, end of token or end of line, with out_last on the final event
//   caused by an input byte. A byte causes zero to six events.
//   A byte's first event is valid once it has passed the input register and
//   been loaded into the result buffer. Throughput: one byte per cycle while
//   each byte causes at most one event and out_ready is high; a byte with
//   more events holds the result buffer until all are taken. A held byte that
//   causes events is processed only when the result buffer is empty or drains
//   its last event, so a stalled receiver backs up into the input register and
//   then drops in_ready; events are never lost. Reset clears the line, quote,
//   comment and token state and empties both input register and result buffer.
module console_command_line_lexer #(
  parameter int MAX_TOKENS  = 64,
  parameter int TOKEN_CHARS = 1024,
  parameter int LINE_CHARS  = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte_value,
  input  logic       in_end_of_buffer,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_event_res,
  output logic [7:0] out_char_value,
  output logic [5:0] out_token_index,
  output logic [9:0] out_token_length,
  output logic [6:0] out_token_count,
  output logic       out_last
);
  import ccl_pkg::*;

  logic       iv_r;
  logic [7:0] ib_r;
  logic       ie_r;
  logic       step;
  logic       load_ready;
  ccl_batch_t batch;
  ccl_event_t oev;

  assign step     = iv_r && ((batch.n == '0) || load_ready);
  assign in_ready = !iv_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      iv_r <= 1'b1;
    end else if (step) begin
      iv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ib_r <= in_byte_value;
      ie_r <= in_end_of_buffer;
    end
  end

  ccl_lex #(
    .MAX_TOKENS (MAX_TOKENS),
    .TOKEN_CHARS(TOKEN_CHARS),
    .LINE_CHARS (LINE_CHARS)
  ) u_lex (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .byte_value   (ib_r),
    .end_of_buffer(ie_r),
    .batch        (batch)
  );

  ccl_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step && (batch.n != '0)),
    .batch     (batch),
    .load_ready(load_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_ev    (oev),
    .out_last  (out_last)
  );

  assign out_event_res    = oev.ev;
  assign out_char_value   = oev.chr;
  assign out_token_index  = oev.idx;
  assign out_token_length = oev.len;
  assign out_token_count  = oev.cnt;

endmodule
